### rtl/core/iirg_pkg.sv
// Shared types, constants and rounding function for the gain IIR filter.
`default_nettype none

package iirg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 18;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = PROD_W + 3;
	localparam int REG_IDX_W  = 3;
	localparam int NUM_REGS   = 8;
	localparam int HIST_DEPTH = 3;
	localparam int TERM_W     = 3;
	localparam int FRAC_SHIFT = 14;

	// register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_GAIN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NUM0 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_NUM1 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DEN1 = 3'd5;

	localparam logic signed [COEF_W-1:0] REG_RESET [NUM_REGS] = '{
		18'sd16384, 18'sd16384, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
	};

	localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN  = -ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(8192);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RND,
		ST_HIST,
		ST_X0,
		ST_LAST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              start;
		logic              round_gain;
		logic              issue_hist;
		logic              issue_x0;
		logic              acc_en;
		logic              finish;
		logic [TERM_W-1:0] term;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       clip;
	} sat_t;

	// round half up at 2^-14, then clamp to 16 bits
	function automatic sat_t round_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		sat_t                    res;
		r = (v + RND_BIAS) >>> FRAC_SHIFT;
		res.clip = 1'b0;
		if (r > SAT_MAX) begin
			res.value = SAT_MAX[SAMPLE_W-1:0];
			res.clip  = 1'b1;
		end else if (r < SAT_MIN) begin
			res.value = SAT_MIN[SAMPLE_W-1:0];
			res.clip  = 1'b1;
		end else begin
			res.value = r[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/core/iirg_if.sv
// Channel interfaces: sample input, filtered output and configuration writes.
`default_nettype none

interface iirg_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [iirg_pkg::SAMPLE_W-1:0]  sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface iirg_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [iirg_pkg::SAMPLE_W-1:0]  sample_out;
	logic                                  clipped;
	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface iirg_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [iirg_pkg::REG_IDX_W-1:0]        index;
	logic [iirg_pkg::COEF_W-1:0]           data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/iirg_ctrl.sv
// Sequencer for the shared multiply-accumulate datapath.
`default_nettype none

module iirg_ctrl #(
	parameter int NUM_TAPS = 4,
	parameter int DEN_TAPS = 4
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  iirg_pkg::status_t  status,
	output iirg_pkg::cmd_t     cmd
);

	localparam int HIST_TERMS = (NUM_TAPS - 1) + (DEN_TAPS - 1);
	localparam logic [iirg_pkg::TERM_W-1:0] LAST_TERM = iirg_pkg::TERM_W'(HIST_TERMS - 1);

	iirg_pkg::state_t               state_q;
	iirg_pkg::state_t               state_d;
	logic [iirg_pkg::TERM_W-1:0]    term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iirg_pkg::ST_IDLE;
			term_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == iirg_pkg::ST_HIST) begin
				term_q <= term_q + 1'b1;
			end else begin
				term_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			iirg_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (HIST_TERMS == 0) ? iirg_pkg::ST_RND : iirg_pkg::ST_HIST;
				end
			end
			iirg_pkg::ST_RND:  state_d = iirg_pkg::ST_X0;
			iirg_pkg::ST_HIST: begin
				if (term_q == LAST_TERM) begin
					state_d = iirg_pkg::ST_X0;
				end
			end
			iirg_pkg::ST_X0:   state_d = iirg_pkg::ST_LAST;
			iirg_pkg::ST_LAST: state_d = iirg_pkg::ST_FINISH;
			iirg_pkg::ST_FINISH: begin
				if (!status.out_busy) begin
					state_d = iirg_pkg::ST_IDLE;
				end
			end
			default: state_d = iirg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.term = term_q;
		in_ready = 1'b0;
		case (state_q)
			iirg_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			iirg_pkg::ST_RND: begin
				cmd.round_gain = 1'b1;
			end
			iirg_pkg::ST_HIST: begin
				// gain product is rounded while the first history product forms
				cmd.issue_hist = 1'b1;
				cmd.round_gain = (term_q == '0);
				cmd.acc_en     = (term_q != '0);
			end
			iirg_pkg::ST_X0: begin
				cmd.issue_x0 = 1'b1;
				cmd.acc_en   = (HIST_TERMS != 0);
			end
			iirg_pkg::ST_LAST: begin
				cmd.acc_en = 1'b1;
			end
			iirg_pkg::ST_FINISH: begin
				cmd.finish = !status.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/iirg_dp.sv
// Datapath: coefficient registers, histories, shared multiplier, accumulator, output register.
`default_nettype none

module iirg_dp #(
	parameter int NUM_TAPS = 4,
	parameter int DEN_TAPS = 4
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  iirg_pkg::cmd_t                        cmd,
	output iirg_pkg::status_t                     status,
	input  wire signed [iirg_pkg::SAMPLE_W-1:0]   sample_in,
	input  wire                                   cfg_we,
	input  wire [iirg_pkg::REG_IDX_W-1:0]         cfg_index,
	input  wire [iirg_pkg::COEF_W-1:0]            cfg_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic signed [iirg_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                  clipped
);

	localparam logic [iirg_pkg::TERM_W-1:0] NUM_HT = iirg_pkg::TERM_W'(NUM_TAPS - 1);

	logic signed [iirg_pkg::COEF_W-1:0]   coef_q [iirg_pkg::NUM_REGS];
	logic signed [iirg_pkg::SAMPLE_W-1:0] xh_q [iirg_pkg::HIST_DEPTH];
	logic signed [iirg_pkg::SAMPLE_W-1:0] yh_q [iirg_pkg::HIST_DEPTH];

	logic signed [iirg_pkg::PROD_W-1:0]   prod_s1;
	logic                                 sub_s1;
	logic signed [iirg_pkg::ACC_W-1:0]    acc_q;
	logic signed [iirg_pkg::SAMPLE_W-1:0] x0_q;
	logic                                 gclip_q;
	logic                                 out_valid_q;
	logic signed [iirg_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                                 out_clip_q;

	logic signed [iirg_pkg::COEF_W-1:0]   mul_a;
	logic signed [iirg_pkg::SAMPLE_W-1:0] mul_b;
	logic                                 mul_sub;
	logic [iirg_pkg::TERM_W-1:0]          den_idx;
	iirg_pkg::sat_t                       gain_sat;
	iirg_pkg::sat_t                       out_sat;

	assign den_idx  = cmd.term - NUM_HT;
	assign gain_sat = iirg_pkg::round_sat(iirg_pkg::ACC_W'(prod_s1));
	assign out_sat  = iirg_pkg::round_sat(acc_q);

	// operand select for the shared multiplier
	always_comb begin
		mul_sub = 1'b0;
		if (cmd.start) begin
			mul_a = coef_q[iirg_pkg::REG_GAIN];
			mul_b = sample_in;
		end else if (cmd.issue_x0) begin
			mul_a = coef_q[iirg_pkg::REG_NUM0];
			mul_b = x0_q;
		end else if (cmd.term < NUM_HT) begin
			mul_a = coef_q[iirg_pkg::REG_NUM1 + cmd.term];
			mul_b = xh_q[cmd.term[1:0]];
		end else begin
			mul_a   = coef_q[iirg_pkg::REG_DEN1 + den_idx];
			mul_b   = yh_q[den_idx[1:0]];
			mul_sub = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start || cmd.issue_hist || cmd.issue_x0) begin
			prod_s1 <= iirg_pkg::PROD_W'(mul_a) * iirg_pkg::PROD_W'(mul_b);
			sub_s1  <= mul_sub && !cmd.start && !cmd.issue_x0;
		end
		if (cmd.start) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			if (sub_s1) begin
				acc_q <= acc_q - iirg_pkg::ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + iirg_pkg::ACC_W'(prod_s1);
			end
		end
		if (cmd.round_gain) begin
			x0_q    <= gain_sat.value;
			gclip_q <= gain_sat.clip;
		end
		if (cmd.finish) begin
			out_sample_q <= out_sat.value;
			out_clip_q   <= gclip_q | out_sat.clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iirg_pkg::NUM_REGS; i++) begin
				coef_q[i] <= iirg_pkg::REG_RESET[i];
			end
			for (int i = 0; i < iirg_pkg::HIST_DEPTH; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				coef_q[cfg_index] <= $signed(cfg_data);
			end
			if (cmd.finish) begin
				for (int i = iirg_pkg::HIST_DEPTH - 1; i > 0; i--) begin
					xh_q[i] <= xh_q[i-1];
					yh_q[i] <= yh_q[i-1];
				end
				xh_q[0] <= x0_q;
				yh_q[0] <= out_sat.value;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign sample_out      = out_sample_q;
	assign clipped         = out_clip_q;

endmodule

`default_nettype wire

### rtl/core/iir_filter_with_gain.sv
// Direct form I IIR filter with input gain: top level.
// Channels: din carries one signed Q1.15 sample per beat; dout returns one
// saturated Q1.15 sample plus a clipped flag per input beat, in order.
// cfg writes the eight Q4.14 registers (gain, num 0..3, den 1..3) by index;
// it is always ready and must only be used while no sample is in flight.
// One multiplier is shared: the gain product, then NUM_TAPS + DEN_TAPS - 2
// history products, then the current-sample product, one per cycle.
// An item goes from accept through the history, current-sample, last and
// finish states to the output register (with one tap each, a rounding state
// replaces the history states); din is ready again only in idle, so a new
// sample waits until the last result is in the output register.
// The output register holds a result while the next sample is processed;
// if dout is still stalled when the next result is ready, the block waits
// and din stays low on ready until the pending beat is taken.
// Reset (arst_n low) clears both histories, restores the register reset
// values (gain and num 0 at 1.0, the rest zero) and empties the output.
`default_nettype none

module iir_filter_with_gain #(
	parameter int NUM_TAPS = 4,
	parameter int DEN_TAPS = 4
) (
	input  wire               clk,
	input  wire               arst_n,
	iirg_in_if.sink           din,
	iirg_out_if.source        dout,
	iirg_cfg_if.sink          cfg
);

	iirg_pkg::cmd_t    cmd;
	iirg_pkg::status_t status;

	assign cfg.ready = 1'b1;

	iirg_ctrl #(
		.NUM_TAPS (NUM_TAPS),
		.DEN_TAPS (DEN_TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.status   (status),
		.cmd      (cmd)
	);

	iirg_dp #(
		.NUM_TAPS (NUM_TAPS),
		.DEN_TAPS (DEN_TAPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.sample_in  (din.sample_in),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (dout.valid),
		.out_ready  (dout.ready),
		.sample_out (dout.sample_out),
		.clipped    (dout.clipped)
	);

endmodule

`default_nettype wire

### bench/iir_filter_with_gain_tb.sv
// Self-checking testbench for the gain IIR filter: predictor, stimulus and checks.

module iir_filter_with_gain_tb;

	import iirg_pkg::*;

	localparam int NUM_TAPS   = 4;
	localparam int DEN_TAPS   = 4;
	localparam int IDLE_LIMIT = 3000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       clipped;
	} out_beat_t;

	// Tracks coefficients and both histories, predicts each output beat.
	class filter_scoreboard;
		logic signed [COEF_W-1:0]   coef [NUM_REGS];
		logic signed [SAMPLE_W-1:0] x_hist [HIST_DEPTH];
		logic signed [SAMPLE_W-1:0] y_hist [HIST_DEPTH];
		out_beat_t                  expected_q [$];
		bit                         clip_now;
		int                         mismatches;
		int                         samples_seen;
		int                         outputs_checked;
		int                         clipped_seen;

		function new();
			for (int i = 0; i < NUM_REGS; i++)
				coef[i] = REG_RESET[i];
			for (int i = 0; i < HIST_DEPTH; i++) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			mismatches      = 0;
			samples_seen    = 0;
			outputs_checked = 0;
			clipped_seen    = 0;
		endfunction

		function void write_coef(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
			coef[idx] = val;
		endfunction

		// round half up at 2^-14 (floor shift), clamp to Q1.15
		function logic signed [SAMPLE_W-1:0] round_clamp(longint acc);
			longint r;
			r = (acc + 64'sd8192) >>> FRAC_SHIFT;
			if (r > 32767) begin
				clip_now = 1'b1;
				return 16'sh7fff;
			end
			if (r < -32768) begin
				clip_now = 1'b1;
				return 16'sh8000;
			end
			return r[SAMPLE_W-1:0];
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] s);
			logic signed [SAMPLE_W-1:0] x0;
			logic signed [SAMPLE_W-1:0] y0;
			longint                     acc;
			out_beat_t                  beat;
			clip_now = 1'b0;
			x0  = round_clamp(longint'(coef[REG_GAIN]) * longint'(s));
			acc = longint'(coef[REG_NUM0]) * longint'(x0);
			for (int i = 1; i < NUM_TAPS && i <= HIST_DEPTH; i++)
				acc += longint'(coef[REG_NUM0 + i]) * longint'(x_hist[i-1]);
			for (int i = 1; i < DEN_TAPS && i <= HIST_DEPTH; i++)
				acc -= longint'(coef[REG_DEN1 + i - 1]) * longint'(y_hist[i-1]);
			y0 = round_clamp(acc);
			// saturated values are what the histories keep
			for (int i = HIST_DEPTH - 1; i > 0; i--) begin
				x_hist[i] = x_hist[i-1];
				y_hist[i] = y_hist[i-1];
			end
			x_hist[0] = x0;
			y_hist[0] = y0;
			beat.sample_out = y0;
			beat.clipped    = clip_now;
			expected_q.push_back(beat);
			samples_seen++;
		endfunction

		function void check_output(logic signed [SAMPLE_W-1:0] v, logic c);
			out_beat_t want;
			if (expected_q.size() == 0) begin
				$error("output beat with nothing expected: sample_out %0d clipped %0b", v, c);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			outputs_checked++;
			if (c === 1'b1)
				clipped_seen++;
			if (v !== want.sample_out) begin
				$error("sample_out mismatch: expected %0d, actual %0d", want.sample_out, v);
				mismatches++;
			end
			if (c !== want.clipped) begin
				$error("clipped mismatch: expected %0b, actual %0b", want.clipped, c);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	iirg_in_if  din_if ();
	iirg_out_if dout_if ();
	iirg_cfg_if cfg_if ();

	iir_filter_with_gain #(
		.NUM_TAPS (NUM_TAPS),
		.DEN_TAPS (DEN_TAPS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	filter_scoreboard         sb = new();
	logic signed [COEF_W-1:0] coef_plan [NUM_REGS];
	int                       stim_q [$];
	int                       settings_used;
	int                       idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// beat monitor: feeds the predictor and checks outputs
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				sb.write_coef(cfg_if.index, cfg_if.data);
			if (dout_if.valid && dout_if.ready)
				sb.check_output(dout_if.sample_out, dout_if.clipped);
			if (din_if.valid && din_if.ready)
				sb.note_sample(din_if.sample_in);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// output back-pressure: runs of always-ready, coin flips, long stalls, fixed pattern
	initial begin
		int mode;
		int left;
		dout_if.ready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(4, 60);
			end
			left--;
			case (mode)
				0: dout_if.ready <= 1'b1;
				1: dout_if.ready <= 1'($urandom_range(0, 1));
				2: dout_if.ready <= ($urandom_range(0, 7) == 0);
				default: dout_if.ready <= ((left % 5) != 0);
			endcase
		end
	end

	function automatic int next_sample();
		case ($urandom_range(0, 9))
			0: return 32767;
			1: return -32768;
			2, 3: return int'($urandom_range(0, 512)) - 256;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] wide_coef();
		return COEF_W'($urandom_range(0, (1 << COEF_W) - 1));
	endfunction

	function automatic logic signed [COEF_W-1:0] mild_coef(int span);
		return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// write all registers of coef_plan, valid held high across back-to-back beats
	task automatic load_coefs();
		for (int idx = 0; idx < NUM_REGS; idx++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= REG_IDX_W'(idx);
			cfg_if.data  <= coef_plan[idx];
			do @(posedge clk); while (!cfg_if.ready);
		end
		cfg_if.valid <= 1'b0;
		settings_used++;
	endtask

	// drain all outputs before touching the registers; the first edge lets the
	// monitor record the last input beat before the queue is looked at
	task automatic settle();
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// send stim_q in bursts with random gaps
	task automatic feed_samples();
		int burst_left;
		int gap;
		burst_left = 0;
		foreach (stim_q[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					din_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			din_if.valid     <= 1'b1;
			din_if.sample_in <= SAMPLE_W'(stim_q[i]);
			do @(posedge clk); while (!din_if.ready);
			burst_left--;
		end
		din_if.valid <= 1'b0;
	endtask

	initial begin
		int kind;
		arst_n           = 1'b0;
		din_if.valid     = 1'b0;
		din_if.sample_in = '0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = '0;
		cfg_if.data      = '0;
		idle_cycles      = 0;
		settings_used    = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset coefficients: passthrough, field extremes
		stim_q = '{0, 32767, -32768, 1, -1, 16384, -16384, 32767, 32767, -32768, -32768, 0};
		feed_samples();
		settle();

		// gain of one half: rounding ties go up
		foreach (coef_plan[i])
			coef_plan[i] = '0;
		coef_plan[REG_GAIN] = 18'sd8192;
		coef_plan[REG_NUM0] = 18'sd16384;
		load_coefs();
		stim_q = '{1, -1, 3, -3};
		feed_samples();
		settle();

		// extreme coefficients: scaled input and output both saturate
		coef_plan[REG_GAIN]     = 18'sd131071;
		coef_plan[REG_NUM0]     = 18'sd131071;
		coef_plan[REG_NUM1]     = -18'sd131072;
		coef_plan[REG_NUM1 + 1] = 18'sd131071;
		coef_plan[REG_NUM1 + 2] = -18'sd131072;
		coef_plan[REG_DEN1]     = 18'sd131071;
		coef_plan[REG_DEN1 + 1] = -18'sd131072;
		coef_plan[REG_DEN1 + 2] = -18'sd1;
		load_coefs();
		stim_q = '{4096, -4096, 32767, -32768, 1, 0, -1, 0};
		feed_samples();
		settle();

		for (int p = 0; p < 12; p++) begin
			kind = (p < 3) ? p : (($urandom_range(0, 2) == 0) ? 3 : 4);
			foreach (coef_plan[i]) begin
				case (kind)
					0: coef_plan[i] = 18'sd131071;
					1: coef_plan[i] = -18'sd131072;
					3: coef_plan[i] = wide_coef();
					default: coef_plan[i] = mild_coef(16384);
				endcase
			end
			if (kind == 2)
				coef_plan[REG_GAIN] = '0;
			if (kind >= 2) begin
				// keep the feedback mild most of the time
				coef_plan[REG_DEN1]     = mild_coef(kind == 3 ? 131071 : 6000);
				coef_plan[REG_DEN1 + 1] = mild_coef(kind == 3 ? 131071 : 3000);
				coef_plan[REG_DEN1 + 2] = mild_coef(kind == 3 ? 131071 : 1500);
			end
			load_coefs();
			stim_q.delete();
			repeat (150)
				stim_q.push_back(next_sample());
			feed_samples();
			settle();
		end

		repeat (30) @(posedge clk);
		$display("run covered %0d samples under %0d coefficient settings", sb.samples_seen,
			settings_used);
		$display("%0d output beats checked, %0d of them clipped", sb.outputs_checked,
			sb.clipped_seen);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/iirg_pkg.sv
rtl/core/iirg_if.sv
rtl/core/iirg_ctrl.sv
rtl/core/iirg_dp.sv
rtl/core/iir_filter_with_gain.sv
bench/iir_filter_with_gain_tb.sv
